// File: design/cursor_deque_list_manager_macros.svh
// Assertion macros shared by the list manager RTL.
// Depends on i_clk and i_rst_n being declared in the module that uses them.
`ifndef CURSOR_DEQUE_LIST_MANAGER_MACROS_SVH
`define CURSOR_DEQUE_LIST_MANAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDL_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CDL_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cdl_pkg.sv
// Package for the cursor deque list manager: default sizes, operation
// modes, status codes and link-update kinds. No dependencies.
package cdl_pkg;

    localparam int CDL_DEPTH      = 256;
    localparam int CDL_DATA_WIDTH = 32;

    localparam logic [2:0] MODE_READ       = 3'd0;
    localparam logic [2:0] MODE_WRITE      = 3'd1;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd3;
    localparam logic [2:0] MODE_INSERT     = 3'd4;
    localparam logic [2:0] MODE_POP_BACK   = 3'd5;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd6;
    localparam logic [2:0] MODE_REMOVE     = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_EMPTY   = 2'd0;
    localparam t_kind KIND_TAIL    = 2'd1;
    localparam t_kind KIND_HEAD    = 2'd2;
    localparam t_kind KIND_MIDDLE  = 2'd3;

endpackage

// File: design/cursor_deque_list_manager.sv
// Cursor deque list manager: doubly linked list in node memory with a
// cursor on one element, moved by i_move_cursor and by list edits. Usage:
//   Command channel: drive i_mode, i_index, i_value, i_move_cursor and
//   raise i_start; the beat is taken at an edge where o_busy is low.
//   Result channel: o_done is high for exactly one cycle with o_read_data,
//   o_status, o_list_size, o_cursor_index and o_cursor_data. The receiver
//   cannot stall; results must be taken in that cycle.
// States from accept to o_done: errors and pop of the last element take
//   S_DECIDE, S_FIN, S_OUT; push and insert S_DECIDE, S_PUSH1, S_PW1 up
//   to S_PW3, S_FIN, S_OUT; pop and remove S_DECIDE, S_POP1, S_RW1 and
//   S_RW2 for a middle node, S_FIN, S_OUT; read and write S_DECIDE, then
//   S_WALK over k link steps (at most about DEPTH/2) from the nearest of
//   head, tail or cursor at one step per cycle, then S_FIN, S_OUT.
// One command at a time: o_busy stays high until the cycle after o_done.
// Reset (i_rst_n low, synchronous) empties the list and frees all slots at
// once; no clearing pass is needed.
module cursor_deque_list_manager import cdl_pkg::*; #(
    parameter int DEPTH      = CDL_DEPTH,
    parameter int DATA_WIDTH = CDL_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_index,
    input  logic [31:0] i_value,
    input  logic        i_move_cursor,
    output logic        o_done,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status,
    output logic [8:0]  o_list_size,
    output logic [7:0]  o_cursor_index,
    output logic [31:0] o_cursor_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_PUSH1  = 4'd3;
    localparam logic [3:0] S_PW1    = 4'd4;
    localparam logic [3:0] S_PW2    = 4'd5;
    localparam logic [3:0] S_PW3    = 4'd6;
    localparam logic [3:0] S_POP1   = 4'd7;
    localparam logic [3:0] S_RW1    = 4'd8;
    localparam logic [3:0] S_RW2    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]            r_state;
    logic [2:0]            r_mode;
    logic [15:0]           r_idx;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_move;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [AW-1:0]         r_cslot;
    logic [AW-1:0]         r_cpos;
    logic [CW-1:0]         r_cnt;
    logic [AW-1:0]         r_node;
    logic [AW-1:0]         r_at;
    logic                  r_fwd;
    logic [31:0]           r_rd;
    logic [1:0]            r_status;
    logic [AW-1:0]         r_s;
    logic [AW-1:0]         r_nb;
    logic [AW-1:0]         r_p;
    logic [AW-1:0]         r_n;
    t_kind                 r_kind;

    logic                  mem_we_data;
    logic                  mem_we_next;
    logic                  mem_we_prev;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_wnext;
    logic [AW-1:0]         mem_wprev;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [AW-1:0]         mem_rnext;
    logic [AW-1:0]         mem_rprev;

    logic                  fs_pop;
    logic                  fs_push;
    logic [AW-1:0]         fs_push_slot;
    logic [AW-1:0]         fs_slot;

    logic                  n_accept;
    logic                  cnt_zero;
    logic [CW-1:0]         last;
    logic [AW-1:0]         pos;
    logic [CW-1:0]         pos_c;
    logic [CW-1:0]         cpos_c;
    logic                  in_range;
    logic                  walk_fwd;
    logic [AW-1:0]         walk_node;
    logic [AW-1:0]         walk_at;
    logic                  walk_hit;
    logic [AW-1:0]         walk_step;
    t_kind                 push_kind;
    t_kind                 pop_kind;
    logic [31:0]           cnt_w;
    logic [31:0]           cpos_w;

    cdl_node_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_we_data (mem_we_data),
        .i_we_next (mem_we_next),
        .i_we_prev (mem_we_prev),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_wnext   (mem_wnext),
        .i_wprev   (mem_wprev),
        .i_raddr   (mem_raddr),
        .o_rdata   (mem_rdata),
        .o_rnext   (mem_rnext),
        .o_rprev   (mem_rprev)
    );

    cdl_free_stack #(
        .DEPTH (DEPTH)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (fs_pop),
        .i_push      (fs_push),
        .i_push_slot (fs_push_slot),
        .o_slot      (fs_slot)
    );

    assign n_accept = i_start && (r_state == S_IDLE);
    assign cnt_zero = (r_cnt == '0);
    assign last     = r_cnt - 1'b1;
    assign pos      = r_idx[AW-1:0];
    assign pos_c    = CW'(pos);
    assign cpos_c   = CW'(r_cpos);
    assign in_range = (32'(r_idx) < 32'(r_cnt));
    assign walk_hit = (r_at == pos);
    assign walk_step = r_fwd ? mem_rnext : mem_rprev;

    // pick the nearest starting point for the walk
    always_comb begin
        if (pos_c > cpos_c) begin
            if ((pos_c - cpos_c) < (last - pos_c)) begin
                walk_fwd  = 1'b1;
                walk_node = r_cslot;
                walk_at   = r_cpos;
            end else begin
                walk_fwd  = 1'b0;
                walk_node = r_tail;
                walk_at   = last[AW-1:0];
            end
        end else begin
            if ((cpos_c - pos_c) < pos_c) begin
                walk_fwd  = 1'b0;
                walk_node = r_cslot;
                walk_at   = r_cpos;
            end else begin
                walk_fwd  = 1'b1;
                walk_node = r_head;
                walk_at   = '0;
            end
        end
    end

    always_comb begin
        if (cnt_zero) begin
            push_kind = KIND_EMPTY;
        end else if (r_mode == MODE_PUSH_BACK ||
                     (r_mode == MODE_INSERT && cpos_c == last && r_cpos != '0)) begin
            push_kind = KIND_TAIL;
        end else if (r_mode == MODE_PUSH_FRONT || r_cpos == '0) begin
            push_kind = KIND_HEAD;
        end else begin
            push_kind = KIND_MIDDLE;
        end
        if (r_mode == MODE_POP_BACK ||
            (r_mode == MODE_REMOVE && cpos_c == last && r_cpos != '0)) begin
            pop_kind = KIND_TAIL;
        end else if (r_mode == MODE_POP_FRONT || r_cpos == '0) begin
            pop_kind = KIND_HEAD;
        end else begin
            pop_kind = KIND_MIDDLE;
        end
    end

    // memory and allocator control
    always_comb begin
        mem_we_data  = 1'b0;
        mem_we_next  = 1'b0;
        mem_we_prev  = 1'b0;
        mem_waddr    = r_node;
        mem_wdata    = r_value;
        mem_wnext    = '0;
        mem_wprev    = '0;
        mem_raddr    = r_cslot;
        fs_pop       = 1'b0;
        fs_push      = 1'b0;
        fs_push_slot = r_head;
        case (r_state)
            S_DECIDE: begin
                if (r_mode <= MODE_WRITE) begin
                    mem_raddr = walk_node;
                end else if (r_mode <= MODE_INSERT) begin
                    fs_pop = !(r_mode == MODE_INSERT && cnt_zero) &&
                             (32'(r_cnt) != 32'(DEPTH));
                end else if (r_cnt == CW'(1)) begin
                    fs_push = 1'b1;
                end else begin
                    case (pop_kind)
                        KIND_TAIL: mem_raddr = r_tail;
                        KIND_HEAD: mem_raddr = r_head;
                        default:   mem_raddr = r_cslot;
                    endcase
                end
            end
            S_WALK: begin
                mem_raddr   = walk_step;
                mem_we_data = walk_hit && (r_mode == MODE_WRITE);
            end
            S_PW1: begin
                mem_we_data = 1'b1;
                mem_we_next = 1'b1;
                mem_we_prev = 1'b1;
                mem_waddr   = r_s;
                case (r_kind)
                    KIND_TAIL:   mem_wprev = r_tail;
                    KIND_HEAD:   mem_wnext = r_head;
                    KIND_MIDDLE: begin
                        mem_wnext = r_cslot;
                        mem_wprev = r_p;
                    end
                    default: mem_wnext = '0;
                endcase
            end
            S_PW2: begin
                mem_waddr = r_nb;
                mem_wnext = r_s;
                mem_wprev = r_s;
                if (r_kind == KIND_HEAD) begin
                    mem_we_prev = 1'b1;
                end else begin
                    mem_we_next = 1'b1;
                end
            end
            S_PW3: begin
                mem_waddr   = r_n;
                mem_wprev   = r_s;
                mem_we_prev = 1'b1;
            end
            S_POP1: begin
                fs_push = 1'b1;
                case (r_kind)
                    KIND_TAIL: fs_push_slot = r_tail;
                    KIND_HEAD: fs_push_slot = r_head;
                    default:   fs_push_slot = r_cslot;
                endcase
            end
            S_RW1: begin
                mem_waddr   = r_p;
                mem_wnext   = r_n;
                mem_we_next = 1'b1;
            end
            S_RW2: begin
                mem_waddr   = r_n;
                mem_wprev   = r_p;
                mem_we_prev = 1'b1;
            end
            default: mem_raddr = r_cslot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cslot <= '0;
            r_cpos  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_mode   <= i_mode;
                        r_idx    <= i_index;
                        r_value  <= DATA_WIDTH'(i_value);
                        r_move   <= i_move_cursor;
                        r_rd     <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_FIN;
                    if (r_mode <= MODE_WRITE) begin
                        if (cnt_zero) begin
                            r_status <= ST_EMPTY;
                        end else if (!in_range) begin
                            r_status <= ST_RANGE;
                        end else begin
                            r_node  <= walk_node;
                            r_at    <= walk_at;
                            r_fwd   <= walk_fwd;
                            r_state <= S_WALK;
                        end
                    end else if (r_mode <= MODE_INSERT) begin
                        if (r_mode == MODE_INSERT && cnt_zero) begin
                            r_status <= ST_EMPTY;
                        end else if (32'(r_cnt) == 32'(DEPTH)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_state <= S_PUSH1;
                        end
                    end else begin
                        if (cnt_zero) begin
                            r_status <= ST_EMPTY;
                        end else if (r_cnt == CW'(1)) begin
                            r_head  <= '0;
                            r_tail  <= '0;
                            r_cslot <= '0;
                            r_cpos  <= '0;
                            r_cnt   <= '0;
                        end else begin
                            r_kind  <= pop_kind;
                            r_state <= S_POP1;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_hit) begin
                        if (r_mode == MODE_READ) begin
                            r_rd <= 32'(mem_rdata);
                        end
                        if (r_move && pos != '0 && pos_c != last) begin
                            r_cslot <= r_node;
                            r_cpos  <= pos;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_node <= walk_step;
                        r_at   <= r_fwd ? r_at + 1'b1 : r_at - 1'b1;
                    end
                end
                S_PUSH1: begin
                    r_s     <= fs_slot;
                    r_p     <= mem_rprev;
                    r_kind  <= push_kind;
                    r_state <= S_PW1;
                end
                S_PW1: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_PW2;
                    case (r_kind)
                        KIND_EMPTY: begin
                            r_head  <= r_s;
                            r_tail  <= r_s;
                            r_cslot <= r_s;
                            r_cpos  <= '0;
                            r_state <= S_FIN;
                        end
                        KIND_TAIL: begin
                            r_nb   <= r_tail;
                            r_tail <= r_s;
                            if (r_mode == MODE_INSERT) begin
                                r_cslot <= r_s;
                                r_cpos  <= r_cnt[AW-1:0];
                            end
                        end
                        KIND_HEAD: begin
                            r_nb   <= r_head;
                            r_head <= r_s;
                            if (r_mode == MODE_PUSH_FRONT) begin
                                r_cpos <= r_cpos + 1'b1;
                            end else begin
                                r_cslot <= r_s;
                                r_cpos  <= '0;
                            end
                        end
                        default: begin
                            r_nb    <= r_p;
                            r_n     <= r_cslot;
                            r_cslot <= r_s;
                        end
                    endcase
                end
                S_PW2: begin
                    r_state <= (r_kind == KIND_MIDDLE) ? S_PW3 : S_FIN;
                end
                S_PW3: begin
                    r_state <= S_FIN;
                end
                S_POP1: begin
                    r_cnt   <= last;
                    r_state <= S_FIN;
                    case (r_kind)
                        KIND_TAIL: begin
                            r_tail <= mem_rprev;
                            if (cpos_c >= last) begin
                                r_cslot <= mem_rprev;
                                r_cpos  <= AW'(last - 1'b1);
                            end
                        end
                        KIND_HEAD: begin
                            r_head <= mem_rnext;
                            if (r_cpos != '0) begin
                                r_cpos <= r_cpos - 1'b1;
                            end else begin
                                r_cslot <= mem_rnext;
                            end
                        end
                        default: begin
                            r_p     <= mem_rprev;
                            r_n     <= mem_rnext;
                            r_cslot <= mem_rnext;
                            r_state <= S_RW1;
                        end
                    endcase
                end
                S_RW1: begin
                    r_state <= S_RW2;
                end
                S_RW2: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign cnt_w  = 32'(r_cnt);
    assign cpos_w = 32'(r_cpos);

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = (r_state == S_OUT);
    assign o_read_data    = r_rd;
    assign o_status       = r_status;
    assign o_list_size    = cnt_w[8:0];
    assign o_cursor_index = cnt_zero ? 8'd0 : cpos_w[7:0];
    assign o_cursor_data  = cnt_zero ? 32'd0 : 32'(mem_rdata);

    `include "cursor_deque_list_manager_macros.svh"

    `CDL_AST_NXT(a_accept_busy, n_accept, o_busy, "accepted beat did not raise busy")
    `CDL_AST_NXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")
    `CDL_AST_IMP(a_cnt_bound, 1'b1, 32'(r_cnt) <= 32'(DEPTH), "element count above depth")
    `CDL_AST_IMP(a_empty_cursor, o_done && o_list_size == 9'd0, o_cursor_index == 8'd0 && o_cursor_data == 32'd0, "cursor not cleared on empty list")
    `CDL_AST_IMP(a_full_push, o_done && o_status == ST_FULL, r_mode == MODE_PUSH_BACK || r_mode == MODE_PUSH_FRONT || r_mode == MODE_INSERT, "full status on non-push beat")

endmodule

// File: design/cdl_node_mem.sv
// Node memory: data word plus next and prev links per slot.
// One write port with per-field enables, one registered read port.
module cdl_node_mem import cdl_pkg::*; #(
    parameter int DEPTH      = CDL_DEPTH,
    parameter int DATA_WIDTH = CDL_DATA_WIDTH,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we_data,
    input  logic                  i_we_next,
    input  logic                  i_we_prev,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_wnext,
    input  logic [AW-1:0]         i_wprev,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata,
    output logic [AW-1:0]         o_rnext,
    output logic [AW-1:0]         o_rprev
);

    logic [DATA_WIDTH-1:0] mem_data [DEPTH];
    logic [AW-1:0]         mem_next [DEPTH];
    logic [AW-1:0]         mem_prev [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         r_rnext;
    logic [AW-1:0]         r_rprev;

    always_ff @(posedge i_clk) begin
        if (i_we_data) begin
            mem_data[i_waddr] <= i_wdata;
        end
        if (i_we_next) begin
            mem_next[i_waddr] <= i_wnext;
        end
        if (i_we_prev) begin
            mem_prev[i_waddr] <= i_wprev;
        end
        r_rdata <= mem_data[i_raddr];
        r_rnext <= mem_next[i_raddr];
        r_rprev <= mem_prev[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_rnext = r_rnext;
    assign o_rprev = r_rprev;

endmodule

// File: design/cdl_free_stack.sv
// Free-slot allocator: a stack of recycled slots in memory plus a counter
// of never-used slots. Depends on cdl_pkg.
module cdl_free_stack import cdl_pkg::*; #(
    parameter int DEPTH = CDL_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [AW-1:0] i_push_slot,
    output logic [AW-1:0] o_slot
);

    logic [AW-1:0] mem_slot [DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_fresh;
    logic [AW-1:0] r_mem_slot;
    logic [AW-1:0] r_fresh_slot;
    logic          r_use_mem;
    logic [CW-1:0] n_top;

    assign n_top = r_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem_slot[r_cnt[AW-1:0]] <= i_push_slot;
        end
        r_mem_slot <= mem_slot[n_top[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_fresh   <= '0;
            r_use_mem <= 1'b0;
        end else if (i_push) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_pop) begin
            r_use_mem    <= (r_cnt != '0);
            r_fresh_slot <= r_fresh[AW-1:0];
            if (r_cnt != '0) begin
                r_cnt <= n_top;
            end else begin
                r_fresh <= r_fresh + 1'b1;
            end
        end
    end

    assign o_slot = r_use_mem ? r_mem_slot : r_fresh_slot;

endmodule

// File: tb/sv/tb_cursor_deque_list_manager.sv
`timescale 1ns / 1ps
// Testbench for cursor_deque_list_manager: directed and random command beats
// checked against an in-bench linked-list predictor. Depends on cdl_pkg.
module tb_cursor_deque_list_manager;
    import cdl_pkg::*;

    localparam int NODES = CDL_DEPTH;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic [8:0]  list_size;
        logic [7:0]  cursor_index;
        logic [31:0] cursor_data;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_mode = MODE_READ;
    logic [15:0] i_index = '0;
    logic [31:0] i_value = '0;
    logic        i_move_cursor = 1'b0;
    logic        o_busy;
    logic        o_done;
    logic [31:0] o_read_data;
    logic [1:0]  o_status;
    logic [8:0]  o_list_size;
    logic [7:0]  o_cursor_index;
    logic [31:0] o_cursor_data;

    cursor_deque_list_manager uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [31:0] node_val [NODES];
    int unsigned node_fwd [NODES];
    int unsigned node_bwd [NODES];
    int unsigned slot_stack [NODES];
    int unsigned stack_top, head_at, tail_at, cur_slot, cur_pos, elem_cnt;

    t_result     pending_results [$];
    int          errors = 0;
    int          idle_cycles = 0;
    logic        busy_seen = 1'b0;
    int          burst_left = 0;

    function automatic int unsigned node_at(int unsigned pos);
        int unsigned last, at, node, steps;
        bit fwd;
        last = elem_cnt - 1;
        steps = 0;
        if (pos > cur_pos) begin
            if (pos - cur_pos < last - pos) begin
                fwd = 1; at = cur_pos; node = cur_slot;
            end else begin
                fwd = 0; at = last; node = tail_at;
            end
        end else begin
            if (cur_pos - pos < pos) begin
                fwd = 0; at = cur_pos; node = cur_slot;
            end else begin
                fwd = 1; at = 0; node = head_at;
            end
        end
        while (at != pos && steps < NODES) begin
            if (fwd) begin
                node = node_fwd[node]; at++;
            end else begin
                node = node_bwd[node]; at--;
            end
            steps++;
        end
        return node;
    endfunction

    function automatic void free_slot(int unsigned s);
        if (stack_top < NODES) begin
            slot_stack[stack_top] = s;
            stack_top++;
        end
    endfunction

    function automatic void clear_list();
        head_at = 0; tail_at = 0; cur_slot = 0; cur_pos = 0; elem_cnt = 0;
    endfunction

    function automatic t_result list_apply(logic [2:0] mode, logic [15:0] idx,
                                           logic [31:0] val, logic mv);
        t_result r;
        int unsigned n, s, old, last;
        bit at_tail, at_head;
        r = '0;
        n = elem_cnt;
        if (mode == MODE_READ || mode == MODE_WRITE) begin
            if (n == 0) r.status = ST_EMPTY;
            else if (idx >= n) r.status = ST_RANGE;
            else begin
                s = node_at(32'(idx));
                if (mode == MODE_READ) r.read_data = node_val[s];
                else node_val[s] = val;
                if (mv && idx != 0 && idx != n - 1) begin
                    cur_slot = s; cur_pos = 32'(idx);
                end
            end
        end else if (mode == MODE_PUSH_BACK || mode == MODE_PUSH_FRONT ||
                     mode == MODE_INSERT) begin
            if (mode == MODE_INSERT && n == 0) r.status = ST_EMPTY;
            else if (stack_top == 0 || n >= NODES) r.status = ST_FULL;
            else begin
                stack_top--;
                s = slot_stack[stack_top];
                node_val[s] = val; node_fwd[s] = 0; node_bwd[s] = 0;
                if (n == 0) begin
                    head_at = s; tail_at = s; cur_slot = s; cur_pos = 0;
                end else if (mode == MODE_PUSH_BACK || (mode == MODE_INSERT &&
                             cur_pos == n - 1 && cur_pos != 0)) begin
                    node_bwd[s] = tail_at;
                    node_fwd[tail_at] = s;
                    tail_at = s;
                    if (mode == MODE_INSERT) begin
                        cur_slot = s; cur_pos = n;
                    end
                end else if (mode == MODE_PUSH_FRONT || cur_pos == 0) begin
                    node_fwd[s] = head_at;
                    node_bwd[head_at] = s;
                    head_at = s;
                    if (mode == MODE_PUSH_FRONT) cur_pos++;
                    else begin
                        cur_slot = s; cur_pos = 0;
                    end
                end else begin
                    old = cur_slot;
                    node_fwd[s] = old;
                    node_bwd[s] = node_bwd[old];
                    node_fwd[node_bwd[old]] = s;
                    node_bwd[old] = s;
                    cur_slot = s;
                end
                elem_cnt = n + 1;
            end
        end else begin
            if (n == 0) r.status = ST_EMPTY;
            else if (n == 1) begin
                free_slot(head_at);
                clear_list();
            end else begin
                last = n - 1;
                at_tail = (mode == MODE_POP_BACK) ||
                          (mode == MODE_REMOVE && cur_pos == last && cur_pos != 0);
                at_head = (mode == MODE_POP_FRONT) || (mode == MODE_REMOVE && cur_pos == 0);
                if (at_tail) begin
                    old = tail_at;
                    tail_at = node_bwd[old];
                    free_slot(old);
                    if (cur_pos >= last) begin
                        cur_slot = tail_at; cur_pos = last - 1;
                    end
                end else if (at_head) begin
                    old = head_at;
                    head_at = node_fwd[old];
                    free_slot(old);
                    if (cur_pos > 0) cur_pos--;
                    else cur_slot = head_at;
                end else begin
                    old = cur_slot;
                    node_fwd[node_bwd[old]] = node_fwd[old];
                    node_bwd[node_fwd[old]] = node_bwd[old];
                    cur_slot = node_fwd[old];
                    free_slot(old);
                end
                elem_cnt = last;
            end
        end
        r.list_size = elem_cnt[8:0];
        r.cursor_index = (elem_cnt == 0) ? 8'd0 : cur_pos[7:0];
        r.cursor_data = (elem_cnt == 0) ? 32'd0 : node_val[cur_slot];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(negedge i_clk) begin
        t_result want;
        busy_seen <= o_busy;
        if (o_done) begin
            if (pending_results.size() == 0) report("unexpected beat", 0, 0);
            else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_read_data !== want.read_data)
                    report("read_data", o_read_data, want.read_data);
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_list_size !== want.list_size)
                    report("list_size", o_list_size, want.list_size);
                if (o_cursor_index !== want.cursor_index)
                    report("cursor_index", o_cursor_index, want.cursor_index);
                if (o_cursor_data !== want.cursor_data)
                    report("cursor_data", o_cursor_data, want.cursor_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !busy_seen)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_cmd(logic [2:0] mode, logic [15:0] idx, logic [31:0] val, logic mv);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_start <= 1'b1;
        i_mode <= mode;
        i_index <= idx;
        i_value <= val;
        i_move_cursor <= mv;
        forever begin
            @(posedge i_clk);
            if (!busy_seen) break;
        end
        pending_results.insert(pending_results.size(), list_apply(mode, idx, val, mv));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_list();
        send_cmd(MODE_READ, 16'd0, 32'd0, 1'b1);
        send_cmd(MODE_WRITE, 16'hFFFF, 32'hFFFFFFFF, 1'b1);
        send_cmd(MODE_INSERT, 16'd0, 32'h1, 1'b0);
        send_cmd(MODE_POP_BACK, 16'd0, 32'd0, 1'b0);
        send_cmd(MODE_POP_FRONT, 16'd0, 32'd0, 1'b0);
        send_cmd(MODE_REMOVE, 16'd0, 32'd0, 1'b0);
    endtask

    task automatic test_cursor_moves();
        send_cmd(MODE_PUSH_BACK, 16'd0, 32'hAAAA0001, 1'b0);
        send_cmd(MODE_PUSH_BACK, 16'd0, 32'hFFFFFFFF, 1'b0);
        send_cmd(MODE_PUSH_FRONT, 16'd0, 32'h00000000, 1'b0);
        send_cmd(MODE_PUSH_BACK, 16'd0, 32'h55555555, 1'b0);
        send_cmd(MODE_READ, 16'd0, 32'd0, 1'b1);
        send_cmd(MODE_READ, 16'd3, 32'd0, 1'b1);
        send_cmd(MODE_READ, 16'd4, 32'd0, 1'b0);
        send_cmd(MODE_WRITE, 16'd2, 32'h12345678, 1'b1);
        send_cmd(MODE_INSERT, 16'd0, 32'hDEADBEEF, 1'b0);
        send_cmd(MODE_REMOVE, 16'd0, 32'd0, 1'b0);
        send_cmd(MODE_READ, 16'd1, 32'd0, 1'b1);
        send_cmd(MODE_POP_FRONT, 16'd0, 32'd0, 1'b0);
        send_cmd(MODE_INSERT, 16'd0, 32'h0F0F0F0F, 1'b0);
        send_cmd(MODE_REMOVE, 16'd0, 32'd0, 1'b0);
        send_cmd(MODE_READ, 16'd2, 32'd0, 1'b1);
        send_cmd(MODE_INSERT, 16'd0, 32'hF0F0F0F0, 1'b0);
        send_cmd(MODE_REMOVE, 16'd0, 32'd0, 1'b0);
        send_cmd(MODE_POP_BACK, 16'd0, 32'd0, 1'b0);
        while (elem_cnt != 0) send_cmd(MODE_POP_BACK, 16'd0, 32'd0, 1'b0);
    endtask

    task automatic test_full_list();
        while (elem_cnt < NODES)
            send_cmd($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, 16'd0,
                     $urandom, 1'b0);
        send_cmd(MODE_PUSH_BACK, 16'd0, 32'h1, 1'b0);
        send_cmd(MODE_PUSH_FRONT, 16'd0, 32'h2, 1'b0);
        send_cmd(MODE_INSERT, 16'd0, 32'h3, 1'b0);
        send_cmd(MODE_READ, 16'd128, 32'd0, 1'b1);
        send_cmd(MODE_READ, 16'd255, 32'd0, 1'b1);
        send_cmd(MODE_READ, 16'd256, 32'd0, 1'b1);
        send_cmd(MODE_WRITE, 16'd60, 32'h5A5A5A5A, 1'b1);
        send_cmd(MODE_READ, 16'd200, 32'd0, 1'b0);
        while (elem_cnt > 4)
            send_cmd($urandom_range(0, 2) == 0 ? MODE_REMOVE :
                     ($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT),
                     16'd0, 32'd0, 1'b0);
    endtask

    task automatic test_random_mix(int count);
        int r, grow;
        logic [15:0] idx;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) drain();
            r = $urandom_range(0, 99);
            grow = (elem_cnt < 8) ? 40 : (elem_cnt < 40) ? 22 : 8;
            if (elem_cnt != 0 && $urandom_range(0, 9) != 0)
                idx = 16'($urandom_range(0, elem_cnt - 1));
            else idx = 16'($urandom);
            if (r < grow)
                send_cmd($urandom_range(0, 2) == 0 ? MODE_INSERT :
                         ($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT),
                         16'($urandom), $urandom, 1'($urandom));
            else if (r < 58)
                send_cmd($urandom_range(0, 2) == 0 ? MODE_REMOVE :
                         ($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT),
                         16'($urandom), $urandom, 1'($urandom));
            else
                send_cmd($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, idx, $urandom,
                         1'($urandom));
        end
    endtask

    initial begin
        for (int k = 0; k < NODES; k++) begin
            slot_stack[k] = k;
            node_val[k] = '0; node_fwd[k] = 0; node_bwd[k] = 0;
        end
        stack_top = NODES;
        clear_list();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_cursor_moves();
        test_full_list();
        test_random_mix(610);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: cursor_deque_list_manager.f
+incdir+design
design/cdl_pkg.sv
design/cdl_node_mem.sv
design/cdl_free_stack.sv
design/cursor_deque_list_manager.sv
tb/sv/tb_cursor_deque_list_manager.sv
